@@ sv/plgf_pkg.sv @@
// ----------------------------------------------------------------------------
// plgf_pkg
// Shared types and constants for the peak limiter gain follower: controller
// states, controller/datapath command and status bundles, register indexes.
// ----------------------------------------------------------------------------
package plgf_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

	localparam int SAMPLE_W = 24;
	localparam int CEIL_W   = 24;
	localparam int COEFF_W  = 32;
	localparam int GAIN_W   = 33;

	// unity gain in Q1.32
	localparam logic [GAIN_W-1:0] ONE_Q32 = 33'h1_0000_0000;

	localparam logic              ENABLE_RST  = 1'b1;
	localparam logic [CEIL_W-1:0]  CEILING_RST = 24'd16585117;
	localparam logic [COEFF_W-1:0] RELEASE_RST = 32'd4293178026;

	// restoring divider, one quotient bit per step
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_CMP,
		S_RMUL,
		S_RADD,
		S_GWR,
		S_OUT
	} plgf_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic cmp;
		logic rmul;
		logic radd;
		logic gwr;
		logic out_load;
	} plgf_cmd_t;

	typedef struct packed {
		logic bypass;
		logic over;
		logic attack;
	} plgf_stat_t;

endpackage

@@ sv/plgf_ctrl.sv @@
// ----------------------------------------------------------------------------
// plgf_ctrl
// Sequencer for one sample: target setup, divide, attack/release update,
// output multiply, and the output register's valid flag.
// ----------------------------------------------------------------------------
module plgf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_stall,
	input  plgf_pkg::plgf_stat_t  stat,
	output logic                  in_stall,
	output logic                  out_valid,
	output plgf_pkg::plgf_cmd_t   cmd
);
	import plgf_pkg::*;

	plgf_state_t           state_q;
	plgf_state_t           state_d;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  out_valid_q;
	logic                  in_take;
	logic                  out_take;
	logic                  out_free;
	logic                  div_last;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_take) state_d = S_PREP;
			end
			S_PREP: begin
				if (stat.bypass)    state_d = S_OUT;
				else if (stat.over) state_d = S_DIV;
				else                state_d = S_CMP;
			end
			S_DIV: begin
				if (div_last) state_d = S_CMP;
			end
			S_CMP: begin
				if (stat.attack) state_d = S_GWR;
				else             state_d = S_RMUL;
			end
			S_RMUL: state_d = S_RADD;
			S_RADD: state_d = S_GWR;
			S_GWR:  state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load     = in_take;
			S_PREP: cmd.prep     = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_CMP:  cmd.cmp      = 1'b1;
			S_RMUL: cmd.rmul     = 1'b1;
			S_RADD: cmd.radd     = 1'b1;
			S_GWR:  cmd.gwr      = 1'b1;
			S_OUT:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 1'b1;
			else                  div_cnt_q <= '0;
			if (cmd.out_load)  out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_take_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_PREP))
		else $error("accepted sample did not start processing");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && div_last |=> (state_q == S_CMP))
		else $error("divider did not finish after its last step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_valid_q && out_stall
		|=> (state_q == S_OUT) && out_valid_q)
		else $error("result left while output register still held");
`endif

endmodule

@@ sv/plgf_dp.sv @@
// ----------------------------------------------------------------------------
// plgf_dp
// Limiter datapath: configuration registers, per-channel gains, restoring
// divider for the target gain, one shared multiplier, output register.
// ----------------------------------------------------------------------------
module plgf_dp #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [plgf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data,
	input  logic signed [plgf_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 channel_sel,
	input  plgf_pkg::plgf_cmd_t                  cmd,
	output plgf_pkg::plgf_stat_t                 stat,
	output logic signed [plgf_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 channel_out
);
	import plgf_pkg::*;

	logic                       enable_q;
	logic [CEIL_W-1:0]          ceiling_q;
	logic [COEFF_W-1:0]         coeff_q;
	logic [GAIN_W-1:0]          gain_q [NUM_CHANNELS];

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       sel_q;
	logic                       bypass_q;
	logic [CEIL_W:0]            mag_q;
	logic [CEIL_W-1:0]          rem_q;
	logic [GAIN_W-1:0]          t_q;
	logic [GAIN_W-1:0]          d_q;
	logic [GAIN_W-1:0]          gnew_q;
	logic signed [2*GAIN_W-1:0] prod_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       channel_out_q;

	logic [SAMPLE_W:0]          x_ext;
	logic [SAMPLE_W:0]          x_abs;
	logic [CEIL_W:0]            mag_in;
	logic [CEIL_W:0]            rem2;
	logic                       rem_ge;
	logic [GAIN_W-1:0]          g_cur;
	logic [COEFF_W-1:0]         k_low;
	logic [GAIN_W-1:0]          inc;
	logic signed [GAIN_W-1:0]   mul_a;
	logic signed [GAIN_W-1:0]   mul_b;

	// magnitude as unsigned Q1.24: |x| * 2
	assign x_ext  = {sample_in[SAMPLE_W-1], sample_in};
	assign x_abs  = x_ext[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - x_ext) : x_ext;
	assign mag_in = {x_abs[CEIL_W-1:0], 1'b0};

	// remainder stays below the magnitude, so rem2 fits in 25 bits
	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = (rem2 >= mag_q);

	always_comb begin
		g_cur = ONE_Q32;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (sel_q == 1'(i)) g_cur = gain_q[i];
		end
	end

	// release step: floor(d * (2^32 - c) / 2^32), full-scale operands taken aside
	assign k_low = COEFF_W'(0) - coeff_q;
	always_comb begin
		if (coeff_q == '0)     inc = d_q;
		else if (d_q[GAIN_W-1]) inc = {1'b0, k_low};
		else                   inc = {1'b0, prod_q[63:32]};
	end

	assign mul_a = cmd.rmul ? $signed({1'b0, d_q[COEFF_W-1:0]})
	                        : $signed({{(GAIN_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q});
	assign mul_b = cmd.rmul ? $signed({1'b0, k_low})
	                        : $signed({1'b0, gnew_q[COEFF_W-1:0]});

	assign stat.bypass = bypass_q;
	assign stat.over   = (mag_q > {1'b0, ceiling_q});
	assign stat.attack = (t_q < g_cur);

	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= ENABLE_RST;
			ceiling_q <= CEILING_RST;
			coeff_q   <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				CFG_CEILING: ceiling_q <= cfg_data[CEIL_W-1:0];
				CFG_RELEASE: coeff_q   <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) gain_q[i] <= ONE_Q32;
		end else if (cmd.gwr) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (sel_q == 1'(i)) gain_q[i] <= gnew_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= sample_in;
			sel_q    <= channel_sel;
			mag_q    <= mag_in;
			bypass_q <= !enable_q || (int'(channel_sel) >= NUM_CHANNELS);
		end
		if (cmd.prep) begin
			rem_q <= ceiling_q;
			t_q   <= stat.over ? '0 : ONE_Q32;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? CEIL_W'(rem2 - mag_q) : rem2[CEIL_W-1:0];
			t_q   <= {t_q[GAIN_W-2:0], rem_ge};
		end
		if (cmd.cmp) begin
			gnew_q <= stat.attack ? t_q : g_cur;
			d_q    <= t_q - g_cur;
		end
		if (cmd.radd) gnew_q <= gnew_q + inc;
		if (cmd.rmul || cmd.gwr) prod_q <= (2*GAIN_W)'(mul_a) * (2*GAIN_W)'(mul_b);
		if (cmd.out_load) begin
			sample_out_q  <= (bypass_q || gnew_q[GAIN_W-1]) ? x_q : prod_q[55:32];
			channel_out_q <= sel_q;
		end
	end

`ifndef ASSERT_OFF
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gwr |-> (gnew_q <= ONE_Q32))
		else $error("gain above unity written back");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> ({1'b0, rem_q} < mag_q))
		else $error("divider remainder not below divisor");

	a_bypass_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && bypass_q |=> (sample_out_q == $past(x_q)))
		else $error("bypassed sample was altered");
`endif

endmodule

@@ sv/peak_limiter_gain_follower.sv @@
// ----------------------------------------------------------------------------
// peak_limiter_gain_follower
// Two-channel peak limiter with instant attack and one-pole release.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A sample whose magnitude exceeds the
// ceiling runs the 32-step restoring divider that forms the target gain,
// and then its gain either drops straight to the target or releases; a
// sample at or under the ceiling skips the divider, and a bypassed one
// (limiter off or channel out of range) skips the gain update. The result
// sits in an output register, so the next sample is taken while a finished
// result still waits downstream.
// Configuration writes are always ready and must only happen while idle.
module peak_limiter_gain_follower #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [plgf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [plgf_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 channel_sel,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [plgf_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 channel_out
);
	import plgf_pkg::*;

	plgf_cmd_t  cmd;
	plgf_stat_t stat;

	assign cfg_ready = 1'b1;

	plgf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	plgf_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   (sample_in),
		.channel_sel (channel_sel),
		.cmd         (cmd),
		.stat        (stat),
		.sample_out  (sample_out),
		.channel_out (channel_out)
	);

endmodule
